### hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL files of the audio jitter buffer.
// No dependencies; include by bare file name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define AJB_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define AJB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: next-cycle check failed");

`endif

### hw/rtl/ajb_pkg.sv
// Package of the audio jitter buffer: sizes, operation, status and mode codes,
// and the command struct between controller and datapath. No dependencies.
package ajb_pkg;

	localparam int FRAME_SIZE  = 32;
	localparam int FRAME_COUNT = 20;
	localparam int STORE_DEPTH = FRAME_SIZE * FRAME_COUNT;
	localparam int PTR_W       = $clog2(STORE_DEPTH);
	localparam int CNT_W       = (FRAME_SIZE > 1) ? $clog2(FRAME_SIZE) : 1;
	localparam int SAMPLE_W    = 16;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 8;
	localparam int PREFETCH_W  = 5;
	localparam int LIMIT_W     = 8;
	localparam int OVF_W       = 16;
	localparam int THR_W       = 16;

	// Operations
	localparam logic [1:0] OP_PUT = 2'd0;
	localparam logic [1:0] OP_GET = 2'd1;
	localparam logic [1:0] OP_EOP = 2'd2;

	// Result status
	localparam logic [1:0] STS_OK      = 2'd0;
	localparam logic [1:0] STS_OVF     = 2'd1;
	localparam logic [1:0] STS_DROP    = 2'd2;
	localparam logic [1:0] STS_SILENCE = 2'd3;

	// Playback modes
	localparam logic [1:0] MODE_IDLE = 2'd0;
	localparam logic [1:0] MODE_BUF  = 2'd1;
	localparam logic [1:0] MODE_PLAY = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_PREFETCH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LIMIT    = 2'd1;

	localparam logic [PREFETCH_W-1:0] PREFETCH_RST = 5'd16;
	localparam logic [LIMIT_W-1:0]    LIMIT_RST    = 8'd200;

	// Controller to datapath commands
	typedef struct packed {
		logic put_acc;
		logic get_acc;
		logic eop_acc;
		logic issue;
		logic issue_last;
	} ajb_cmd_t;

endpackage

### hw/rtl/ajb_ctrl.sv
// Controller of the audio jitter buffer: request acceptance and frame sequencing.
// Depends on ajb_pkg.
module ajb_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [1:0]           operation,
	output logic                 busy,
	output ajb_pkg::ajb_cmd_t    cmd
);
	import ajb_pkg::*;

	localparam logic ST_IDLE  = 1'b0;
	localparam logic ST_FRAME = 1'b1;

	logic             state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             accept;
	logic             cnt_last;

	assign busy     = (state_q == ST_FRAME);
	assign accept   = start && !busy;
	assign cnt_last = (cnt_q == CNT_W'(FRAME_SIZE - 1));

	// Decode the accepted request and the frame read slot
	always_comb begin
		cmd.put_acc    = accept && (operation == OP_PUT);
		cmd.get_acc    = accept && (operation == OP_GET);
		cmd.eop_acc    = accept && (operation == OP_EOP);
		cmd.issue      = (state_q == ST_FRAME);
		cmd.issue_last = (state_q == ST_FRAME) && cnt_last;
	end

	// Step through one frame, one sample per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (cmd.get_acc) begin
						state_q <= ST_FRAME;
					end
				end
				ST_FRAME: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_last) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

### hw/rtl/ajb_datapath.sv
// Datapath of the audio jitter buffer: sample ring, positions, playback mode,
// counters, configuration registers and the result register. Depends on ajb_pkg.
module ajb_datapath (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  ajb_pkg::ajb_cmd_t                     cmd,
	input  logic signed [ajb_pkg::SAMPLE_W-1:0]   sample_in,
	input  logic                                  cfg_we,
	input  logic [ajb_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [ajb_pkg::CFG_DATA_W-1:0]        cfg_data,
	output logic                                  strobe,
	output logic signed [ajb_pkg::SAMPLE_W-1:0]   sample_out,
	output logic                                  last,
	output logic [1:0]                            status,
	output logic [ajb_pkg::PTR_W-1:0]             available,
	output logic [1:0]                            mode,
	output logic [ajb_pkg::OVF_W-1:0]             overflow_count
);
	import ajb_pkg::*;

	logic [SAMPLE_W-1:0]   mem [STORE_DEPTH];
	logic [SAMPLE_W-1:0]   rdata_q;

	logic [PTR_W-1:0]      wr_ptr_q, rd_ptr_q, addr_q;
	logic [1:0]            mode_q;
	logic [LIMIT_W-1:0]    uf_q;
	logic                  pend_q;
	logic [OVF_W-1:0]      ovf_q;
	logic [PREFETCH_W-1:0] prefetch_q;
	logic [LIMIT_W-1:0]    limit_q;
	logic [PTR_W-1:0]      avail_f_q;
	logic                  play_q;

	logic                  strobe_q, last_q, zero_q;
	logic [1:0]            status_q, mode_o_q;
	logic [PTR_W-1:0]      avail_o_q;
	logic [OVF_W-1:0]      ovf_o_q;

	logic [PTR_W-1:0]      avail;
	logic [THR_W-1:0]      thr;
	logic [PTR_W-1:0]      wr_inc;
	logic [PTR_W:0]        rd_adv;
	logic [LIMIT_W:0]      uf_inc;
	logic [PTR_W-1:0]      wr_d, rd_d;
	logic [1:0]            mode_d;
	logic [LIMIT_W-1:0]    uf_d;
	logic                  pend_d;
	logic [OVF_W-1:0]      ovf_d;
	logic [1:0]            put_status;
	logic                  mem_we;

	// Fill level, prefetch threshold and pointer increments
	always_comb begin
		if (wr_ptr_q >= rd_ptr_q) begin
			avail = wr_ptr_q - rd_ptr_q;
		end else begin
			avail = PTR_W'({1'b0, wr_ptr_q} + (PTR_W+1)'(STORE_DEPTH) - {1'b0, rd_ptr_q});
		end
		thr    = THR_W'(prefetch_q) * THR_W'(FRAME_SIZE);
		wr_inc = (wr_ptr_q == PTR_W'(STORE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
		rd_adv = {1'b0, rd_ptr_q} + (PTR_W+1)'(FRAME_SIZE);
		uf_inc = {1'b0, uf_q} + (LIMIT_W+1)'(1);
	end

	// Next state for put, get and end of packet
	always_comb begin
		wr_d       = wr_ptr_q;
		rd_d       = rd_ptr_q;
		mode_d     = mode_q;
		uf_d       = uf_q;
		pend_d     = pend_q;
		ovf_d      = ovf_q;
		put_status = STS_OK;
		mem_we     = 1'b0;
		if (cmd.put_acc) begin
			priority if (pend_q) begin
				put_status = STS_DROP;
			end else if (wr_inc == rd_ptr_q) begin
				put_status = STS_OVF;
				if (ovf_q != '1) begin
					ovf_d = ovf_q + OVF_W'(1);
				end
			end else begin
				mem_we = 1'b1;
				wr_d   = wr_inc;
				if (mode_q == MODE_IDLE) begin
					mode_d = MODE_BUF;
				end
			end
		end
		if (cmd.eop_acc && pend_q) begin
			pend_d = 1'b0;
			wr_d   = '0;
		end
		if (cmd.get_acc) begin
			if (mode_q == MODE_BUF) begin
				if (THR_W'(avail) >= thr) begin
					mode_d = MODE_PLAY;
				end else if (uf_inc > {1'b0, limit_q}) begin
					mode_d = MODE_IDLE;
					uf_d   = '0;
					rd_d   = '0;
					pend_d = 1'b1;
				end else begin
					uf_d = uf_inc[LIMIT_W-1:0];
				end
			end else if (mode_q == MODE_PLAY) begin
				if (avail < PTR_W'(FRAME_SIZE)) begin
					mode_d = MODE_BUF;
					if (uf_q != '1) begin
						uf_d = uf_q + LIMIT_W'(1);
					end
				end else begin
					uf_d = '0;
				end
			end
			// Advance the read position by one frame when playing
			if (mode_d == MODE_PLAY) begin
				rd_d = (rd_adv >= (PTR_W+1)'(STORE_DEPTH)) ? '0 : rd_adv[PTR_W-1:0];
			end
		end
	end

	// Control state and configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			mode_q     <= MODE_IDLE;
			uf_q       <= '0;
			pend_q     <= 1'b0;
			ovf_q      <= '0;
			prefetch_q <= PREFETCH_RST;
			limit_q    <= LIMIT_RST;
			strobe_q   <= 1'b0;
		end else begin
			wr_ptr_q <= wr_d;
			rd_ptr_q <= rd_d;
			mode_q   <= mode_d;
			uf_q     <= uf_d;
			pend_q   <= pend_d;
			ovf_q    <= ovf_d;
			strobe_q <= cmd.put_acc || cmd.eop_acc || cmd.issue;
			if (cfg_we && (cfg_index == CFG_PREFETCH)) begin
				prefetch_q <= cfg_data[PREFETCH_W-1:0];
			end
			if (cfg_we && (cfg_index == CFG_LIMIT)) begin
				limit_q <= cfg_data[LIMIT_W-1:0];
			end
		end
	end

	// Sample ring: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_ptr_q] <= sample_in;
		end
		rdata_q <= mem[addr_q];
	end

	// Frame read address and per-frame fields
	always_ff @(posedge clk) begin
		if (cmd.get_acc) begin
			addr_q    <= rd_ptr_q;
			avail_f_q <= avail;
			play_q    <= (mode_d == MODE_PLAY);
		end else if (cmd.issue) begin
			addr_q <= (addr_q == PTR_W'(STORE_DEPTH - 1)) ? '0 : addr_q + PTR_W'(1);
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.put_acc || cmd.eop_acc) begin
			last_q    <= 1'b1;
			status_q  <= cmd.put_acc ? put_status : STS_OK;
			avail_o_q <= avail;
			mode_o_q  <= mode_d;
			ovf_o_q   <= ovf_d;
			zero_q    <= 1'b1;
		end else if (cmd.issue) begin
			last_q    <= cmd.issue_last;
			status_q  <= play_q ? STS_OK : STS_SILENCE;
			avail_o_q <= avail_f_q;
			mode_o_q  <= mode_q;
			ovf_o_q   <= ovf_q;
			zero_q    <= !play_q;
		end
	end

	assign strobe         = strobe_q;
	assign sample_out     = zero_q ? '0 : signed'(rdata_q);
	assign last           = last_q;
	assign status         = status_q;
	assign available      = avail_o_q;
	assign mode           = mode_o_q;
	assign overflow_count = ovf_o_q;

endmodule

### hw/rtl/audio_jitter_buffer.sv
// Audio jitter buffer top level: controller, datapath and checks.
// Depends on ajb_pkg, ajb_ctrl, ajb_datapath and assert_macros.svh.
//
// Requests: raise start with operation and sample_in; the request is taken
// at the clock edge where start is high and busy is low.
// Put and end of packet: one result, shown on strobe in the cycle after the
// request is taken; a new request can be taken every cycle.
// Get: 32 results on strobe in consecutive cycles, the first once the
// controller is in its frame state and the result register is loaded;
// busy stays high while the frame is read out of the sample ring, one
// sample per cycle through its read port, and no request is taken meanwhile.
// The last result carries last. Operation 3 is taken and gives no result.
// Results are held for one cycle only; the receiver cannot stall them.
// Configuration: cfg_valid with cfg_index/cfg_data, cfg_ready is always high;
// write only while no request is in flight.
// Reset (arst_n low) empties the ring, sets mode idle, clears all counters
// and loads prefetch 16 and underflow limit 200; the ring contents are not
// cleared, and no clearing pass is needed.
module audio_jitter_buffer (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic [1:0]                            operation,
	input  logic signed [ajb_pkg::SAMPLE_W-1:0]   sample_in,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [ajb_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [ajb_pkg::CFG_DATA_W-1:0]        cfg_data,
	output logic                                  strobe,
	output logic signed [ajb_pkg::SAMPLE_W-1:0]   sample_out,
	output logic                                  last,
	output logic [1:0]                            status,
	output logic [ajb_pkg::PTR_W-1:0]             available,
	output logic [1:0]                            mode,
	output logic [ajb_pkg::OVF_W-1:0]             overflow_count
);
	import ajb_pkg::*;

	`include "assert_macros.svh"

	ajb_cmd_t cmd;

	assign cfg_ready = 1'b1;

	// Sequence requests and frames
	ajb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.operation (operation),
		.busy      (busy),
		.cmd       (cmd)
	);

	// Hold samples, state and results
	ajb_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sample_in      (sample_in),
		.cfg_we         (cfg_valid && cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.strobe         (strobe),
		.sample_out     (sample_out),
		.last           (last),
		.status         (status),
		.available      (available),
		.mode           (mode),
		.overflow_count (overflow_count)
	);

	// A taken get occupies the block in the next cycle
	`AJB_ASSERT_NEXT(a_get_busy, clk, arst_n, cmd.get_acc, busy)
	// A taken put or end of packet gives exactly one final result next cycle
	`AJB_ASSERT_NEXT(a_single_result, clk, arst_n, cmd.put_acc || cmd.eop_acc, strobe && last)
	// Frame results come without gaps until the last one
	`AJB_ASSERT_NEXT(a_frame_contig, clk, arst_n, strobe && !last, strobe)
	// Fill level never reaches the ring depth
	`AJB_ASSERT_SAME(a_avail_range, clk, arst_n, strobe, available < PTR_W'(STORE_DEPTH))

endmodule

### test/audio_jitter_buffer_tb.sv
// Testbench for the audio jitter buffer: directed and random requests, with
// an in-order prediction of every result. Depends on ajb_pkg and the
// audio_jitter_buffer top level.
module audio_jitter_buffer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ajb_pkg::*;

	localparam logic [1:0]           OP_UNUSED   = 2'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED  = 2'd3;
	localparam int                   TAIL_CYCLES = 40;
	localparam int                   MAX_CYCLES  = 1_000_000;
	localparam int                   MAX_REPORTS = 10;

	typedef struct {
		logic signed [SAMPLE_W-1:0] smp;
		logic                       fin;
		logic [1:0]                 sts;
		logic [PTR_W-1:0]           avail;
		logic [1:0]                 md;
		logic [OVF_W-1:0]           ovf;
	} buffer_result_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        start = 1'b0;
	logic                        busy;
	logic [1:0]                  operation = OP_PUT;
	logic signed [SAMPLE_W-1:0]  sample_in = '0;
	logic                        cfg_valid = 1'b0;
	logic                        cfg_ready;
	logic [CFG_IDX_W-1:0]        cfg_index = CFG_PREFETCH;
	logic [CFG_DATA_W-1:0]       cfg_data = '0;
	logic                        strobe;
	logic signed [SAMPLE_W-1:0]  sample_out;
	logic                        last;
	logic [1:0]                  status;
	logic [PTR_W-1:0]            available;
	logic [1:0]                  mode;
	logic [OVF_W-1:0]            overflow_count;

	// Predicted buffer state
	logic signed [SAMPLE_W-1:0]  ring [STORE_DEPTH];
	bit                          ring_written [STORE_DEPTH];
	int                          wr_pos = 0;
	int                          rd_pos = 0;
	logic [1:0]                  play_state = MODE_IDLE;
	int                          underflows = 0;
	bit                          reset_armed = 1'b0;
	int                          rejected_puts = 0;
	int                          prefetch_level = 16;
	int                          underflow_cap = 200;

	buffer_result_t              due_results [$];
	int                          mismatches = 0;
	int                          cycles = 0;
	bit                          gapless = 1'b0;

	audio_jitter_buffer dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.operation      (operation),
		.sample_in      (sample_in),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.strobe         (strobe),
		.sample_out     (sample_out),
		.last           (last),
		.status         (status),
		.available      (available),
		.mode           (mode),
		.overflow_count (overflow_count)
	);

	always #4 clk = ~clk;

	// Stop a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > MAX_CYCLES) begin
			$display("[audio_jitter_buffer] ERROR");
			$finish;
		end
	end

	function automatic int stored_samples();
		if (wr_pos >= rd_pos)
			return wr_pos - rd_pos;
		return STORE_DEPTH - (rd_pos - wr_pos);
	endfunction

	function automatic void queue_result(logic signed [SAMPLE_W-1:0] smp, logic fin,
			logic [1:0] sts, int avail_now);
		buffer_result_t r;
		r.smp   = smp;
		r.fin   = fin;
		r.sts   = sts;
		r.avail = PTR_W'(avail_now);
		r.md    = play_state;
		r.ovf   = OVF_W'(rejected_puts);
		due_results.push_back(r);
	endfunction

	// Advance the buffer by one accepted request and queue what it emits
	function automatic void advance_buffer(logic [1:0] op, logic signed [SAMPLE_W-1:0] smp);
		int         fill;
		int         nxt;
		int         base;
		logic [1:0] sts;
		fill = stored_samples();
		case (op)
			OP_PUT: begin
				if (reset_armed) begin
					sts = STS_DROP;
				end else begin
					nxt = (wr_pos + 1 >= STORE_DEPTH) ? 0 : wr_pos + 1;
					if (nxt == rd_pos) begin
						if (rejected_puts < 65535)
							rejected_puts++;
						sts = STS_OVF;
					end else begin
						ring[wr_pos] = smp;
						ring_written[wr_pos] = 1'b1;
						wr_pos = nxt;
						if (play_state == MODE_IDLE)
							play_state = MODE_BUF;
						sts = STS_OK;
					end
				end
				queue_result('0, 1'b1, sts, fill);
			end
			OP_EOP: begin
				if (reset_armed) begin
					reset_armed = 1'b0;
					wr_pos = 0;
				end
				queue_result('0, 1'b1, STS_OK, fill);
			end
			OP_GET: begin
				// Decide the playback mode first, then stream the frame
				if (play_state == MODE_BUF) begin
					if (fill >= prefetch_level * FRAME_SIZE) begin
						play_state = MODE_PLAY;
					end else begin
						nxt = underflows + 1;
						if (nxt > underflow_cap) begin
							play_state = MODE_IDLE;
							underflows = 0;
							rd_pos = 0;
							reset_armed = 1'b1;
						end else begin
							underflows = nxt;
						end
					end
				end else if (play_state == MODE_PLAY) begin
					if (fill < FRAME_SIZE) begin
						play_state = MODE_BUF;
						if (underflows < 255)
							underflows++;
					end else begin
						underflows = 0;
					end
				end
				if (play_state == MODE_PLAY) begin
					base = rd_pos;
					rd_pos = (base + FRAME_SIZE >= STORE_DEPTH) ? 0 : base + FRAME_SIZE;
					for (int i = 0; i < FRAME_SIZE; i++)
						queue_result(ring[(base + i) % STORE_DEPTH], i == FRAME_SIZE - 1,
							STS_OK, fill);
				end else begin
					for (int i = 0; i < FRAME_SIZE; i++)
						queue_result('0, i == FRAME_SIZE - 1, STS_SILENCE, fill);
				end
			end
			default: ;
		endcase
	endfunction

	// True when a get now would read ring entries that were never written
	function automatic bit frame_unwritten();
		int fill;
		bit plays;
		fill = stored_samples();
		plays = (play_state == MODE_BUF && fill >= prefetch_level * FRAME_SIZE) ||
			(play_state == MODE_PLAY && fill >= FRAME_SIZE);
		if (!plays)
			return 1'b0;
		for (int i = 0; i < FRAME_SIZE; i++)
			if (!ring_written[(rd_pos + i) % STORE_DEPTH])
				return 1'b1;
		return 1'b0;
	endfunction

	// Compare each strobed result with the oldest expectation
	always @(posedge clk) begin
		buffer_result_t want;
		if (arst_n && strobe === 1'b1) begin
			if (due_results.size() == 0) begin
				if (mismatches < MAX_REPORTS)
					$display("unexpected result: sample %0d last %0b status %0d avail %0d",
						sample_out, last, status, available);
				mismatches++;
			end else begin
				want = due_results.pop_front();
				if (sample_out !== want.smp || last !== want.fin || status !== want.sts ||
						available !== want.avail || mode !== want.md ||
						overflow_count !== want.ovf) begin
					if (mismatches < MAX_REPORTS)
						$display({"mismatch: expected sample %0d last %0b status %0d avail %0d",
							" mode %0d ovf %0d, got sample %0d last %0b status %0d avail %0d",
							" mode %0d ovf %0d"}, want.smp, want.fin, want.sts, want.avail,
							want.md, want.ovf, sample_out, last, status, available, mode,
							overflow_count);
					mismatches++;
				end
			end
		end
	end

	// Send one request, with a random gap ahead of it unless gapless
	task automatic send_request(logic [1:0] op, logic signed [SAMPLE_W-1:0] smp);
		while (!gapless && $urandom_range(99) < 14) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start     <= 1'b1;
		operation <= op;
		sample_in <= smp;
		do
			@(posedge clk);
		while (busy !== 1'b0);
		advance_buffer(op, smp);
	endtask

	// Hold requests off until every result is in and the block has gone quiet
	task automatic wait_idle();
		start <= 1'b0;
		while (due_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	// Write both registers back to back; optionally hit the unused index too
	task automatic program_registers(logic [4:0] frames, logic [7:0] cap, bit touch_unused);
		logic [CFG_DATA_W-1:0] word;
		wait_idle();
		word = {3'($urandom_range(7)), frames};
		cfg_valid <= 1'b1;
		cfg_index <= CFG_PREFETCH;
		cfg_data  <= word;
		do
			@(posedge clk);
		while (cfg_ready !== 1'b1);
		prefetch_level = int'(frames);
		cfg_index <= CFG_LIMIT;
		cfg_data  <= cap;
		do
			@(posedge clk);
		while (cfg_ready !== 1'b1);
		underflow_cap = int'(cap);
		if (touch_unused) begin
			cfg_index <= CFG_UNUSED;
			cfg_data  <= 8'hFF;
			do
				@(posedge clk);
			while (cfg_ready !== 1'b1);
		end
		cfg_valid <= 1'b0;
	endtask

	// Force a buffer reset and finish it, leaving an empty idle ring
	task automatic drain_to_idle();
		program_registers(5'd20, 8'd0, 1'b0);
		send_request(OP_EOP, 16'($urandom()));
		send_request(OP_PUT, 16'($urandom()));
		while (play_state != MODE_IDLE)
			send_request(OP_GET, 16'($urandom()));
		send_request(OP_EOP, 16'($urandom()));
	endtask

	task automatic test_basic_ops();
		send_request(OP_GET, 16'sh1234);
		send_request(OP_EOP, 16'sh0000);
		send_request(OP_UNUSED, 16'shFFFF);
		send_request(OP_PUT, 16'sh7FFF);
		send_request(OP_PUT, -16'sh8000);
		send_request(OP_PUT, 16'sh0000);
		send_request(OP_PUT, -16'sh0001);
		send_request(OP_GET, 16'sh0000);
		send_request(OP_EOP, 16'sh5A5A);
	endtask

	// Play a frame, underflow past the limit, then finish the reset
	task automatic test_play_and_reset();
		program_registers(5'd1, 8'd2, 1'b1);
		repeat (36) send_request(OP_PUT, 16'($urandom()));
		repeat (4) send_request(OP_GET, 16'($urandom()));
		send_request(OP_PUT, 16'($urandom()));
		send_request(OP_GET, 16'($urandom()));
		send_request(OP_EOP, 16'($urandom()));
		send_request(OP_PUT, 16'($urandom()));
		send_request(OP_EOP, 16'($urandom()));
	endtask

	// Fill the ring, overflow it, wrap both positions, then read stale data
	task automatic test_ring_wrap();
		drain_to_idle();
		program_registers(5'd20, 8'd200, 1'b0);
		repeat (STORE_DEPTH - 1) send_request(OP_PUT, 16'($urandom()));
		repeat (2) send_request(OP_PUT, 16'($urandom()));
		send_request(OP_GET, 16'($urandom()));
		program_registers(5'd19, 8'd200, 1'b0);
		repeat (19) send_request(OP_GET, 16'($urandom()));
		repeat (20) send_request(OP_PUT, 16'($urandom()));
		repeat (2) send_request(OP_GET, 16'($urandom()));
		program_registers(5'd0, 8'd200, 1'b0);
		repeat (3) send_request(OP_GET, 16'($urandom()));
	endtask

	// Drive the underflow counter to its ceiling through a short playback
	task automatic test_underflow_saturation();
		drain_to_idle();
		send_request(OP_PUT, 16'($urandom()));
		program_registers(5'd1, 8'd255, 1'b0);
		repeat (255) send_request(OP_GET, 16'($urandom()));
		repeat (FRAME_SIZE - 1) send_request(OP_PUT, 16'($urandom()));
		repeat (3) send_request(OP_GET, 16'($urandom()));
		send_request(OP_EOP, 16'($urandom()));
	endtask

	task automatic test_random_traffic();
		int sent;
		int burst;
		int roll;
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: program_registers(5'd1, 8'($urandom_range(7)), 1'b0);
				1: program_registers(5'($urandom_range(3)), 8'd255, 1'b0);
				2: program_registers(5'd2, 8'd0, 1'b0);
				default: program_registers(5'($urandom_range(1, 19)), 8'($urandom()), 1'b0);
			endcase
			// Long stretch without gaps in one phase
			gapless = (phase == 1);
			sent = 0;
			while (sent < 75) begin
				roll = $urandom_range(99);
				if (roll < 55) begin
					burst = $urandom_range(1, 48);
					repeat (burst) send_request(OP_PUT, 16'($urandom()));
					sent += burst;
					if ($urandom_range(4) != 0) begin
						send_request(OP_EOP, 16'($urandom()));
						sent++;
					end
				end else if (roll < 90) begin
					if (frame_unwritten())
						send_request(OP_EOP, 16'($urandom()));
					else
						send_request(OP_GET, 16'($urandom()));
					sent++;
				end else if (roll < 95) begin
					send_request(OP_UNUSED, 16'($urandom()));
				end else begin
					wait_idle();
				end
			end
		end
		gapless = 1'b0;
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_basic_ops();
		test_play_and_reset();
		test_ring_wrap();
		test_underflow_saturation();
		test_random_traffic();
		wait_idle();
		if (mismatches == 0 && due_results.size() == 0) begin
			$display("[audio_jitter_buffer] OK");
		end else begin
			$display("[audio_jitter_buffer] ERROR");
		end
		$finish;
	end

endmodule

### audio_jitter_buffer.f
+incdir+hw/rtl
hw/rtl/ajb_pkg.sv
hw/rtl/ajb_ctrl.sv
hw/rtl/ajb_datapath.sv
hw/rtl/audio_jitter_buffer.sv
test/audio_jitter_buffer_tb.sv
